// ===== rtl/nsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the netstring deframer.
// No dependencies; imported by nsd_parser, netstring_deframer and the testbench.
package nsd_pkg;

    localparam int CFG_W   = 24;
    localparam int ACC_W   = 27;
    localparam int DIGIT_W = 4;

    localparam logic [CFG_W-1:0] RST_MAX_FRAME = CFG_W'(1048576);
    localparam logic [DIGIT_W-1:0] MAX_HDR_DIGITS = DIGIT_W'(8);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_LAST    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_INVALID_HEADER = 2'd0;
    localparam logic [1:0] ERR_LEADING_ZERO   = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE      = 2'd2;
    localparam logic [1:0] ERR_NO_TERMINATOR  = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TERM    = 2'd2,
        PH_ERROR   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } t_result;

    localparam logic [CFG_W-1:0] POW10 [7] = '{
        CFG_W'(10), CFG_W'(100), CFG_W'(1000), CFG_W'(10000),
        CFG_W'(100000), CFG_W'(1000000), CFG_W'(10000000)
    };

    // Decimal digit count of a value, 1 for zero.
    function automatic logic [DIGIT_W-1:0] dec_digits(input logic [CFG_W-1:0] v);
        logic [DIGIT_W-1:0] n;
        n = DIGIT_W'(1);
        for (int k = 0; k < 7; k++) begin
            if (v >= POW10[k]) begin
                n = n + DIGIT_W'(1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/netstring_deframer.sv =====
`timescale 1ns / 1ps
// Netstring deframer: one stream byte per cycle in, payload bytes, frame-end and error
// requests out. Depends on nsd_pkg and nsd_parser.
//
// The block takes one byte per clock cycle in steady state. A byte is captured in the
// input register and its result, if any, is loaded from there into the output register,
// which presents it until it is taken; the byte stays in the input register while the
// output register is full. The rate is set by the per-byte update of the parse state
// (the times-ten length accumulator and its compare against the limit). The input side
// stalls only while the output register holds a result that has not been taken. Header
// bytes and the colon give no result unless they are in error; after any error every
// byte returns the same error until reset.
module netstring_deframer
    import nsd_pkg::*;
#(
    parameter int LEN_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,    // max_frame_bytes
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,     // [7:0] in_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,     // [7:0] out_byte, [9:8] error_code
    output logic [1:0]        o_m_tuser      // [1:0] kind
);

    localparam int MAX_W = (LEN_BITS < CFG_W) ? LEN_BITS : CFG_W;
    localparam logic [MAX_W-1:0] RST_MAX = MAX_W'(RST_MAX_FRAME);

    logic [MAX_W-1:0]   r_max;
    logic [DIGIT_W-1:0] r_max_digits;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    t_result            r_out;

    logic    w_out_free, w_proc, w_res_valid;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= RST_MAX;
            r_max_digits <= dec_digits(CFG_W'(RST_MAX));
        end else if (i_cfg_valid) begin
            r_max        <= i_cfg_data[MAX_W-1:0];
            r_max_digits <= dec_digits(CFG_W'(i_cfg_data[MAX_W-1:0]));
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    nsd_parser #(
        .MAX_W (MAX_W)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_proc),
        .i_byte       (r_in_byte),
        .i_max        (r_max),
        .i_max_digits (r_max_digits),
        .o_valid      (w_res_valid),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.err, r_out.data};
    assign o_m_tuser  = r_out.kind;

endmodule

// ===== rtl/nsd_parser.sv =====
`timescale 1ns / 1ps
// Parse state and per-byte result logic of the netstring deframer.
// Depends on nsd_pkg.
module nsd_parser
    import nsd_pkg::*;
#(
    parameter int MAX_W = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic [MAX_W-1:0]   i_max,
    input  logic [DIGIT_W-1:0] i_max_digits,
    output logic               o_valid,
    output t_result            o_res
);

    t_phase             r_phase, n_phase;
    logic [DIGIT_W-1:0] r_digit_count, n_digit_count;
    logic               r_first_zero, n_first_zero;
    logic [ACC_W-1:0]   r_accum, n_accum;
    logic [MAX_W-1:0]   r_remaining, n_remaining;
    logic [1:0]         r_sticky, n_sticky;

    logic w_is_digit, w_is_colon, w_lead0, w_dig_big, w_len_big;
    logic [ACC_W-1:0] w_accum_next;

    assign w_is_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_is_colon   = (i_byte == CH_COLON);
    assign w_lead0      = (r_digit_count != '0) && r_first_zero;
    assign w_dig_big    = (r_digit_count >= i_max_digits);
    assign w_len_big    = (r_accum > ACC_W'(i_max));
    assign w_accum_next = (r_accum << 3) + (r_accum << 1) + ACC_W'(i_byte - CH_ZERO);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_digit_count = r_digit_count;
        n_first_zero  = r_first_zero;
        n_accum       = r_accum;
        n_remaining   = r_remaining;
        n_sticky      = r_sticky;
        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    if (w_is_digit) begin
                        if (w_lead0) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ERR_LEADING_ZERO;
                        end else if (w_dig_big) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ERR_TOO_LARGE;
                        end else begin
                            if (r_digit_count == '0) begin
                                n_first_zero = (i_byte == CH_ZERO);
                            end
                            n_accum       = w_accum_next;
                            n_digit_count = r_digit_count + DIGIT_W'(1);
                        end
                    end else if (w_is_colon) begin
                        if (r_digit_count == '0) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ERR_INVALID_HEADER;
                        end else if (w_len_big) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ERR_TOO_LARGE;
                        end else begin
                            n_remaining   = MAX_W'(r_accum);
                            n_phase       = (r_accum != '0) ? PH_PAYLOAD : PH_TERM;
                            n_digit_count = '0;
                            n_first_zero  = 1'b0;
                            n_accum       = '0;
                        end
                    end else begin
                        n_phase  = PH_ERROR;
                        n_sticky = ERR_INVALID_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    n_remaining = r_remaining - MAX_W'(1);
                    if (r_remaining == MAX_W'(1)) begin
                        n_phase = PH_TERM;
                    end
                end
                PH_TERM: begin
                    if (i_byte == CH_COMMA) begin
                        n_phase       = PH_HEADER;
                        n_digit_count = '0;
                        n_first_zero  = 1'b0;
                        n_accum       = '0;
                    end else begin
                        n_phase  = PH_ERROR;
                        n_sticky = ERR_NO_TERMINATOR;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_valid    = 1'b0;
        o_res.kind = KIND_ERROR;
        o_res.data = 8'd0;
        o_res.err  = r_sticky;
        case (r_phase)
            PH_HEADER: begin
                if (w_is_digit) begin
                    o_valid   = w_lead0 || w_dig_big;
                    o_res.err = w_lead0 ? ERR_LEADING_ZERO : ERR_TOO_LARGE;
                end else if (w_is_colon) begin
                    o_valid   = (r_digit_count == '0) || w_len_big;
                    o_res.err = (r_digit_count == '0) ? ERR_INVALID_HEADER : ERR_TOO_LARGE;
                end else begin
                    o_valid   = 1'b1;
                    o_res.err = ERR_INVALID_HEADER;
                end
            end
            PH_PAYLOAD: begin
                o_valid    = 1'b1;
                o_res.kind = KIND_PAYLOAD;
                o_res.data = i_byte;
                o_res.err  = 2'd0;
            end
            PH_TERM: begin
                o_valid = 1'b1;
                if (i_byte == CH_COMMA) begin
                    o_res.kind = KIND_LAST;
                    o_res.err  = 2'd0;
                end else begin
                    o_res.err = ERR_NO_TERMINATOR;
                end
            end
            default: begin
                o_valid = 1'b1;
            end
        endcase
        o_valid = o_valid && i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_digit_count <= '0;
            r_first_zero  <= 1'b0;
            r_accum       <= '0;
            r_remaining   <= '0;
            r_sticky      <= 2'd0;
        end else begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_first_zero  <= n_first_zero;
            r_accum       <= n_accum;
            r_remaining   <= n_remaining;
            r_sticky      <= n_sticky;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |=> r_phase == PH_ERROR)
        else $error("left error phase");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= MAX_HDR_DIGITS)
        else $error("header digit count out of range");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != '0)
        else $error("payload phase with nothing remaining");

    a_payload_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.kind == KIND_PAYLOAD |-> r_phase == PH_PAYLOAD)
        else $error("payload byte outside payload phase");

endmodule

// ===== sim/tb_netstring_deframer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for netstring_deframer: drives netstring byte streams and checks
// every payload, frame-end and error request against an in-bench decoder.
// Depends on nsd_pkg and the netstring_deframer RTL.
module tb_netstring_deframer;
    import nsd_pkg::*;

    localparam int LEN_W           = 24;
    localparam int SETTLE_CYC      = 4;
    localparam int HOLD_CYC        = 300;
    localparam int BYTE_TARGET     = 1900;
    localparam int MAX_REPORTS     = 20;
    localparam int TAIL_NOISE      = 40;
    localparam int EXP_DEPTH       = 64;
    localparam logic [1:0] NO_CODE = 2'b00;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata;     // [7:0] in_byte
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [15:0]       o_m_tdata;     // [7:0] out_byte, [9:8] error_code
    logic [1:0]        o_m_tuser;     // [1:0] kind

    netstring_deframer #(
        .LEN_BITS(LEN_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // decoder state
    t_phase           ps_phase;
    int unsigned      ps_digits;
    logic             ps_lead_zero;
    longint unsigned  ps_length;
    logic [LEN_W-1:0] ps_remaining;
    logic [1:0]       ps_error;
    logic [CFG_W-1:0] ps_limit;

    // expected requests, in order
    t_result decoded_mem [EXP_DEPTH];
    int      exp_wr;
    int      exp_rd;

    bit steady_mode;
    bit hold_off_req;
    int fail_count;
    int bytes_sent;
    int limit_writes;
    int payload_seen;
    int frames_seen;
    int errors_seen;
    int tail_case;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        end
        fail_count++;
    endtask

    function automatic void push_record(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [1:0] code);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.err  = code;
        decoded_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic void clear_header();
        ps_digits    = 0;
        ps_lead_zero = 1'b0;
        ps_length    = 0;
    endfunction

    function automatic void latch_error(input logic [1:0] code);
        ps_phase = PH_ERROR;
        ps_error = code;
        push_record(KIND_ERROR, 8'h00, code);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        int unsigned      width;
        logic [CFG_W-1:0] v;
        case (ps_phase)
            PH_HEADER: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    width = 1;
                    v = ps_limit;
                    while (v >= 10) begin
                        v = v / 10;
                        width++;
                    end
                    if (ps_digits >= 1 && ps_lead_zero) begin
                        latch_error(ERR_LEADING_ZERO);
                    end else if (ps_digits + 1 > width) begin
                        latch_error(ERR_TOO_LARGE);
                    end else begin
                        if (ps_digits == 0) begin
                            ps_lead_zero = (b == CH_ZERO);
                        end
                        ps_length = ps_length * 10 + longint'(b - CH_ZERO);
                        ps_digits++;
                    end
                end else if (b == CH_COLON) begin
                    if (ps_digits == 0) begin
                        latch_error(ERR_INVALID_HEADER);
                    end else if (ps_length > ps_limit) begin
                        latch_error(ERR_TOO_LARGE);
                    end else begin
                        ps_remaining = LEN_W'(ps_length);
                        ps_phase = (ps_remaining != 0) ? PH_PAYLOAD : PH_TERM;
                        clear_header();
                    end
                end else begin
                    latch_error(ERR_INVALID_HEADER);
                end
            end
            PH_PAYLOAD: begin
                push_record(KIND_PAYLOAD, b, NO_CODE);
                ps_remaining = ps_remaining - 1'b1;
                if (ps_remaining == 0) begin
                    ps_phase = PH_TERM;
                end
            end
            PH_TERM: begin
                if (b == CH_COMMA) begin
                    ps_phase = PH_HEADER;
                    clear_header();
                    push_record(KIND_LAST, 8'h00, NO_CODE);
                end else begin
                    latch_error(ERR_NO_TERMINATOR);
                end
            end
            default: begin
                push_record(KIND_ERROR, 8'h00, ps_error);
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        while (!steady_mode && $urandom_range(0, 99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    task automatic send_frame(input int unsigned len);
        send_text($sformatf("%0d:", len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_COMMA);
    endtask

    // Hold the input side until every request has come out, then let the pipe settle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ps_limit = v;
        limit_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        send_text("0:,");
        send_text("1:");
        send_byte(8'hFF);
        send_byte(CH_COMMA);
        send_text("3:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(CH_COMMA);
    endtask

    task automatic test_limit_extremes();
        write_limit('0);
        send_text("0:,");
        write_limit('1);
        send_text("2:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_COMMA);
    endtask

    task automatic test_limit_change_mid_frame();
        write_limit(CFG_W'(100));
        send_text("7:");
        write_limit(CFG_W'(1));
        repeat (7) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_COMMA);
    endtask

    task automatic test_output_back_pressure();
        write_limit('1);
        hold_off_req = 1'b1;
        send_frame(64);
        drain();
    endtask

    task automatic test_random_frames();
        int               round;
        int unsigned      cap;
        logic [CFG_W-1:0] lim;
        round = 0;
        while (bytes_sent < BYTE_TARGET) begin
            case (round % 6)
                0:       lim = CFG_W'($urandom_range(1, 60));
                1:       lim = '1;
                2:       lim = '0;
                3:       lim = CFG_W'($urandom);
                4:       lim = CFG_W'(9);
                default: lim = CFG_W'($urandom_range(100, 999));
            endcase
            write_limit(lim);
            steady_mode = (round == 3);
            repeat (12) begin
                cap = (lim > 24) ? 24 : lim;
                if ($urandom_range(0, 7) == 0) begin
                    cap = (lim > 200) ? 200 : lim;
                end
                send_frame($urandom_range(0, cap));
            end
            round++;
        end
        steady_mode = 1'b0;
    endtask

    task automatic test_sticky_error();
        logic [7:0] b;
        write_limit(CFG_W'(1000));
        tail_case = $urandom_range(0, 6);
        case (tail_case)
            0: begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
                send_byte(b);
            end
            1: send_byte(CH_COLON);
            2: begin
                send_byte(CH_ZERO);
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            3: send_text("12345");
            4: send_text("1001:");
            5: begin
                send_text("2:");
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
                send_byte(b);
            end
            default: begin
                send_text("0:");
                do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA);
                send_byte(b);
            end
        endcase
        repeat (TAIL_NOISE) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_m_tready <= steady_mode || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            case (o_m_tuser)
                KIND_PAYLOAD: payload_seen++;
                KIND_LAST:    frames_seen++;
                default:      errors_seen++;
            endcase
            if (exp_wr == exp_rd) begin
                report_mismatch("request with none pending", 0, {o_m_tuser, o_m_tdata});
            end else begin
                want = decoded_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_m_tuser != want.kind) begin
                    report_mismatch("kind", want.kind, o_m_tuser);
                end
                if (o_m_tdata[7:0] != want.data) begin
                    report_mismatch("out_byte", want.data, o_m_tdata[7:0]);
                end
                if (o_m_tdata[9:8] != want.err) begin
                    report_mismatch("error_code", want.err, o_m_tdata[9:8]);
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        steady_mode  = 1'b0;
        hold_off_req = 1'b0;
        exp_wr       = 0;
        exp_rd       = 0;
        ps_phase     = PH_HEADER;
        ps_remaining = '0;
        ps_error     = NO_CODE;
        ps_limit     = RST_MAX_FRAME;
        clear_header();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_limit_extremes();
        test_limit_change_mid_frame();
        test_output_back_pressure();
        test_random_frames();
        test_sticky_error();
        drain();
        repeat (10) @(negedge i_clk);

        $display("Run: %0d bytes, %0d limit writes, %0d payload, %0d frame ends, %0d errors.",
                 bytes_sent, limit_writes, payload_seen, frames_seen, errors_seen);
        $display("Output held off %0d cycles once; sticky-error tail case %0d.",
                 HOLD_CYC, tail_case);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nsd_pkg.sv
rtl/nsd_parser.sv
rtl/netstring_deframer.sv
sim/tb_netstring_deframer.sv
